### src/famb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// famb_pkg
// Shared widths, register indexes, CORDIC constants and stage record types
// for the flow angle / magnitude blend core.
// ----------------------------------------------------------------------------
package famb_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int MAG_BITS      = 12;

  localparam int ANGLE_W = 9;
  localparam int WEIGHT_W = 9;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 9;

  // rotation datapath: Q1.14 unit vectors, angles in 2^-16 degree
  localparam int XW = 18;
  localparam int ZW = 26;
  // vectoring datapath holds the weighted sums (Q1.22) with CORDIC growth
  localparam int VW = 26;

  localparam int ATAN_ENTRIES = 24;
  localparam int ONE_DEG_SHIFT = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_WEIGHT     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_WEIGHT = CFG_IDX_W'(1);

  localparam logic [WEIGHT_W-1:0] ANGLE_WEIGHT_RESET     = WEIGHT_W'(77);
  localparam logic [WEIGHT_W-1:0] MAGNITUDE_WEIGHT_RESET = WEIGHT_W'(128);
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE             = WEIGHT_W'(256);

  localparam logic signed [XW-1:0] CORDIC_START = XW'(9949);
  localparam logic signed [ZW-1:0] DEG_180      = ZW'(180 * 65536);
  localparam logic signed [ZW-1:0] DEG_360      = ZW'(360 * 65536);
  localparam logic signed [ZW-1:0] ANGLE_GUARD  = ZW'(1024);

  localparam logic signed [ZW-1:0] ATAN_DEG16 [ATAN_ENTRIES] = '{
    ZW'(2949120), ZW'(1740967), ZW'(919879), ZW'(466945), ZW'(234379), ZW'(117304),
    ZW'(58666), ZW'(29335), ZW'(14668), ZW'(7334), ZW'(3667), ZW'(1833),
    ZW'(917), ZW'(458), ZW'(229), ZW'(115), ZW'(57), ZW'(29),
    ZW'(14), ZW'(7), ZW'(4), ZW'(2), ZW'(1), ZW'(0)
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } famb_rot_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
  } famb_vec_t;

  // quadrant fixups that ride along the rotation stages
  typedef struct packed {
    logic neg1;
    logic flip1;
    logic neg2;
    logic flip2;
    logic [MAG_BITS-1:0] mag;
  } famb_rot_side_t;

  typedef struct packed {
    logic zero;
    logic [MAG_BITS-1:0] mag;
  } famb_vec_side_t;

endpackage

### src/famb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// famb interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface famb_item_if;
  import famb_pkg::*;
  logic valid;
  logic ready;
  logic [ANGLE_W-1:0]  prev_angle;
  logic [MAG_BITS-1:0] prev_magnitude;
  logic [ANGLE_W-1:0]  new_angle;
  logic [MAG_BITS-1:0] new_magnitude;
  modport source (output valid, prev_angle, prev_magnitude, new_angle, new_magnitude,
                  input ready);
  modport sink (input valid, prev_angle, prev_magnitude, new_angle, new_magnitude,
                output ready);
endinterface

interface famb_result_if;
  import famb_pkg::*;
  logic valid;
  logic ready;
  logic [ANGLE_W-1:0]  blended_angle;
  logic [MAG_BITS-1:0] blended_magnitude;
  logic                zero_sum;
  modport source (output valid, blended_angle, blended_magnitude, zero_sum,
                  input ready);
  modport sink (input valid, blended_angle, blended_magnitude, zero_sum,
                output ready);
endinterface

interface famb_cfg_if;
  import famb_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/flow_angle_magnitude_blend_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_angle_magnitude_blend_core
// Weighted circular mean of two directions and linear blend of two magnitudes.
//
//   channel  dir  beat contents
//   item     in   prev_angle, prev_magnitude, new_angle, new_magnitude
//   result   out  blended_angle, blended_magnitude, zero_sum
//   cfg      in   index, data (angle_weight = 0, magnitude_weight = 1)
//
// one item per cycle while the output register is empty or taken; the CORDIC
// rotation and vectoring chains run one iteration per stage.
// all stages advance together while the output register is empty or taken,
// so a stall freezes the pipe with nothing lost or repeated.
// rst is synchronous; it clears valid bits and loads the weight defaults.
// cfg beats are always accepted.
// ----------------------------------------------------------------------------
module flow_angle_magnitude_blend_core (
  input logic clk,
  input logic rst,
  famb_item_if.sink     item,
  famb_result_if.source result,
  famb_cfg_if.sink      cfg
);
  import famb_pkg::*;

  typedef struct packed {
    logic [6:0] t;
    logic       neg;
    logic       flip;
  } famb_pre_t;

  logic [WEIGHT_W-1:0] angle_weight;
  logic [WEIGHT_W-1:0] magnitude_weight;

  logic adv;

  famb_rot_t      r1 [CORDIC_STAGES+1];
  famb_rot_t      r2 [CORDIC_STAGES+1];
  famb_rot_side_t rs [CORDIC_STAGES+1];
  logic           rv [CORDIC_STAGES+1];

  logic signed [VW-1:0] wsx;
  logic signed [VW-1:0] wsy;
  logic [MAG_BITS-1:0]  wmag;
  logic                 wv;

  famb_vec_t      vc [CORDIC_STAGES+1];
  famb_vec_side_t vs [CORDIC_STAGES+1];
  logic           vv [CORDIC_STAGES+1];

  logic                 ov;
  logic [ANGLE_W-1:0]   o_angle;
  logic [MAG_BITS-1:0]  o_mag;
  logic                 o_zero;

  function automatic famb_pre_t prep(input logic [ANGLE_W-1:0] deg);
    logic [ANGLE_W-1:0] d;
    logic signed [ANGLE_W:0] s;
    logic signed [ANGLE_W:0] t;
    famb_pre_t p;
    d = (deg >= ANGLE_W'(360)) ? deg - ANGLE_W'(360) : deg;
    s = $signed({1'b0, d});
    if (s > 180) s = s - 10'sd360;
    t = s;
    p.flip = 1'b0;
    if (s > 90) begin
      t = s - 10'sd180;
      p.flip = 1'b1;
    end else if (s < -90) begin
      t = s + 10'sd180;
      p.flip = 1'b1;
    end
    p.neg = t[ANGLE_W];
    if (p.neg) t = -t;
    p.t = t[6:0];
    return p;
  endfunction

  function automatic famb_rot_t rot_step(input famb_rot_t a, input int i);
    famb_rot_t b;
    if (a.z >= 0) begin
      b.x = a.x - (a.y >>> i);
      b.y = a.y + (a.x >>> i);
      b.z = a.z - ATAN_DEG16[i];
    end else begin
      b.x = a.x + (a.y >>> i);
      b.y = a.y - (a.x >>> i);
      b.z = a.z + ATAN_DEG16[i];
    end
    return b;
  endfunction

  function automatic famb_vec_t vec_step(input famb_vec_t a, input int i);
    famb_vec_t b;
    if (a.y >= 0) begin
      b.x = a.x + (a.y >>> i);
      b.y = a.y - (a.x >>> i);
      b.z = a.z + ATAN_DEG16[i];
    end else begin
      b.x = a.x - (a.y >>> i);
      b.y = a.y + (a.x >>> i);
      b.z = a.z - ATAN_DEG16[i];
    end
    return b;
  endfunction

  function automatic logic signed [XW-1:0] fix_sign(input logic signed [XW-1:0] v,
                                                    input logic neg);
    return neg ? -v : v;
  endfunction

  function automatic logic [WEIGHT_W-1:0] clamp_w(input logic [WEIGHT_W-1:0] w);
    return (w > WEIGHT_ONE) ? WEIGHT_ONE : w;
  endfunction

  assign adv = !ov || result.ready;
  assign item.ready = adv;
  assign cfg.ready = 1'b1;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_weight     <= ANGLE_WEIGHT_RESET;
      magnitude_weight <= MAGNITUDE_WEIGHT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ANGLE_WEIGHT:     angle_weight <= cfg.data;
        REG_MAGNITUDE_WEIGHT: magnitude_weight <= cfg.data;
        default: ;
      endcase
    end
  end

  // ---------------- prep stage: quadrant fold, magnitude blend ----------------
  famb_pre_t p1, p2;
  logic [WEIGHT_W-1:0] mw;
  logic [MAG_BITS+WEIGHT_W:0] mag_sum;

  always_comb begin
    p1 = prep(item.prev_angle);
    p2 = prep(item.new_angle);
    mw = clamp_w(magnitude_weight);
    mag_sum = (MAG_BITS+WEIGHT_W+1)'(item.prev_magnitude)
              * (MAG_BITS+WEIGHT_W+1)'(WEIGHT_ONE - mw)
            + (MAG_BITS+WEIGHT_W+1)'(item.new_magnitude)
              * (MAG_BITS+WEIGHT_W+1)'(mw);
  end

  always_ff @(posedge clk) begin
    if (rst) rv[0] <= 1'b0;
    else if (adv) rv[0] <= item.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1[0].x <= CORDIC_START;
      r1[0].y <= '0;
      r1[0].z <= ZW'({p1.t, 16'h0000});
      r2[0].x <= CORDIC_START;
      r2[0].y <= '0;
      r2[0].z <= ZW'({p2.t, 16'h0000});
      rs[0].neg1  <= p1.neg;
      rs[0].flip1 <= p1.flip;
      rs[0].neg2  <= p2.neg;
      rs[0].flip2 <= p2.flip;
      rs[0].mag   <= mag_sum[8 +: MAG_BITS];
    end
  end

  // ---------------- rotation chain: unit vectors ----------------
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) rv[i+1] <= 1'b0;
      else if (adv) rv[i+1] <= rv[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        r1[i+1] <= rot_step(r1[i], i);
        r2[i+1] <= rot_step(r2[i], i);
        rs[i+1] <= rs[i];
      end
    end
  end

  // ---------------- weighting stage ----------------
  logic signed [XW-1:0] ux1, uy1, ux2, uy2;
  logic [WEIGHT_W-1:0] aw;
  logic signed [WEIGHT_W:0] w_new, w_old;
  logic signed [XW+WEIGHT_W+1:0] sx_full, sy_full;

  always_comb begin
    ux1 = fix_sign(r1[CORDIC_STAGES].x, rs[CORDIC_STAGES].flip1);
    uy1 = fix_sign(r1[CORDIC_STAGES].y,
                   rs[CORDIC_STAGES].flip1 ^ rs[CORDIC_STAGES].neg1);
    ux2 = fix_sign(r2[CORDIC_STAGES].x, rs[CORDIC_STAGES].flip2);
    uy2 = fix_sign(r2[CORDIC_STAGES].y,
                   rs[CORDIC_STAGES].flip2 ^ rs[CORDIC_STAGES].neg2);
    aw = clamp_w(angle_weight);
    w_new = $signed({1'b0, aw});
    w_old = $signed({1'b0, WEIGHT_ONE - aw});
    sx_full = ux1 * w_old + ux2 * w_new;
    sy_full = uy1 * w_old + uy2 * w_new;
  end

  always_ff @(posedge clk) begin
    if (rst) wv <= 1'b0;
    else if (adv) wv <= rv[CORDIC_STAGES];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wsx  <= VW'(sx_full);
      wsy  <= VW'(sy_full);
      wmag <= rs[CORDIC_STAGES].mag;
    end
  end

  // ---------------- vectoring entry: half-turn for left half plane ----------------
  always_ff @(posedge clk) begin
    if (rst) vv[0] <= 1'b0;
    else if (adv) vv[0] <= wv;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (wsx < 0) begin
        vc[0].x <= -wsx;
        vc[0].y <= -wsy;
        vc[0].z <= DEG_180;
      end else begin
        vc[0].x <= wsx;
        vc[0].y <= wsy;
        vc[0].z <= '0;
      end
      vs[0].zero <= (wsx == '0) && (wsy == '0);
      vs[0].mag  <= wmag;
    end
  end

  // ---------------- vectoring chain: atan2 ----------------
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (rst) vv[i+1] <= 1'b0;
      else if (adv) vv[i+1] <= vv[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        vc[i+1] <= vec_step(vc[i], i);
        vs[i+1] <= vs[i];
      end
    end
  end

  // ---------------- output stage: wrap, guard, truncate ----------------
  logic signed [ZW-1:0] zw, zg;
  logic [ZW-ONE_DEG_SHIFT-1:0] deg_full;
  logic [ANGLE_W-1:0] deg;

  always_comb begin
    zw = vc[CORDIC_STAGES].z;
    if (zw < 0) zw = zw + DEG_360;
    else if (zw >= DEG_360) zw = zw - DEG_360;
    zg = zw + ANGLE_GUARD;
    deg_full = zg[ZW-1:ONE_DEG_SHIFT];
    deg = (deg_full >= (ZW-ONE_DEG_SHIFT)'(360)) ? '0 : deg_full[ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (adv) ov <= vv[CORDIC_STAGES];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_zero  <= vs[CORDIC_STAGES].zero;
      o_mag   <= vs[CORDIC_STAGES].mag;
      o_angle <= vs[CORDIC_STAGES].zero ? '0 : deg;
    end
  end

  assign result.valid             = ov;
  assign result.blended_angle     = o_angle;
  assign result.blended_magnitude = o_mag;
  assign result.zero_sum          = o_zero;

  // ---------------- checks ----------------
  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.zero_sum |-> result.blended_angle == '0)
    else $error("zero sum beat with nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.blended_angle < ANGLE_W'(360))
    else $error("blended angle out of range");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> rv[0])
    else $error("accepted beat missing from prep stage");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vv[CORDIC_STAGES]) && $stable(wv))
    else $error("pipeline moved during stall");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for flow_angle_magnitude_blend_core. A bit-exact model
// of the CORDIC unit vectors, the weighted vector sum, the vectoring angle and
// the magnitude blend predicts every result beat. Directed beats cover field
// extremes, opposite directions that cancel, out-of-range angles and weight
// clamping. Random beats then run under several weight settings, with random
// gaps on the item side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
  import famb_pkg::*;

  localparam int  CYCLE_LIMIT   = 400000;
  localparam int  DRAIN_CYCLES  = 2 * CORDIC_STAGES + 8;
  localparam int  ATAN_LEN      = 24;
  localparam longint DEG_UNIT   = 65536;
  localparam longint HALF_TURN  = 180 * DEG_UNIT;
  localparam longint FULL_TURN  = 360 * DEG_UNIT;
  localparam longint TRUNC_GUARD = 1024;
  localparam longint UNIT_GAIN  = 9949;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = '1;

  // arctan(2^-i) in 2^-16 degree
  localparam longint ARC_STEP [ATAN_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic [ANGLE_W-1:0]  prev_angle;
    logic [MAG_BITS-1:0] prev_magnitude;
    logic [ANGLE_W-1:0]  new_angle;
    logic [MAG_BITS-1:0] new_magnitude;
  } flow_pair_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]  angle;
    logic [MAG_BITS-1:0] magnitude;
    logic                zero;
  } blend_t;

  logic clk;
  logic rst;

  famb_item_if   item_ch ();
  famb_result_if res_ch ();
  famb_cfg_if    cfg_ch ();

  flow_angle_magnitude_blend_core DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  logic [WEIGHT_W-1:0] angle_wt;
  logic [WEIGHT_W-1:0] magnitude_wt;
  blend_t pending_blends [$];
  int     mismatches;
  int     cycle_count;
  bit     calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------------
  function automatic longint weight_eff(input logic [WEIGHT_W-1:0] w);
    return (w > WEIGHT_ONE) ? 256 : longint'(w);
  endfunction

  function automatic void direction_to_unit(input logic [ANGLE_W-1:0] deg,
                                            output longint cx, output longint sy);
    longint s, t, x, y, z, nx;
    bit flip, neg_sin;
    s = longint'(deg);
    if (s >= 360) s -= 360;
    if (s > 180) s -= 360;
    t = s;
    flip = 1'b0;
    if (s > 90) begin
      t = s - 180;
      flip = 1'b1;
    end
    if (s < -90) begin
      t = s + 180;
      flip = 1'b1;
    end
    neg_sin = (t < 0);
    if (neg_sin) t = -t;
    x = UNIT_GAIN;
    y = 0;
    z = t * DEG_UNIT;
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ARC_STEP[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ARC_STEP[i];
      end
      x = nx;
    end
    if (neg_sin) y = -y;
    if (flip) begin
      x = -x;
      y = -y;
    end
    cx = x;
    sy = y;
  endfunction

  function automatic logic [ANGLE_W-1:0] sum_heading(input longint xin, input longint yin);
    longint x, y, z, nx;
    x = xin;
    y = yin;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ARC_STEP[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ARC_STEP[i];
      end
      x = nx;
    end
    while (z < 0) z += FULL_TURN;
    while (z >= FULL_TURN) z -= FULL_TURN;
    z = (z + TRUNC_GUARD) / DEG_UNIT;
    if (z >= 360) z = 0;
    return ANGLE_W'(z);
  endfunction

  function automatic blend_t blend_expected(input flow_pair_t p);
    longint x1, y1, x2, y2, sx, sy, w, m, mag;
    blend_t r;
    direction_to_unit(p.prev_angle, x1, y1);
    direction_to_unit(p.new_angle, x2, y2);
    w = weight_eff(angle_wt);
    m = weight_eff(magnitude_wt);
    sx = x1 * (256 - w) + x2 * w;
    sy = y1 * (256 - w) + y2 * w;
    r.zero  = (sx == 0 && sy == 0);
    r.angle = r.zero ? '0 : sum_heading(sx, sy);
    mag = (longint'(p.prev_magnitude) * (256 - m) + longint'(p.new_magnitude) * m) >>> 8;
    r.magnitude = MAG_BITS'(mag);
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // channel drivers
  // ------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // item valid stays high across back-to-back beats
  task automatic send_pair(input flow_pair_t p);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.prev_angle     <= p.prev_angle;
    item_ch.prev_magnitude <= p.prev_magnitude;
    item_ch.new_angle      <= p.new_angle;
    item_ch.new_magnitude  <= p.new_magnitude;
    do @(posedge clk); while (!item_ch.ready);
    pending_blends.push_back(blend_expected(p));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending_blends.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_ANGLE_WEIGHT:     angle_wt = value;
      REG_MAGNITUDE_WEIGHT: magnitude_wt = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_fields(input int pa, input int pm, input int na, input int nm);
    flow_pair_t p;
    p.prev_angle     = ANGLE_W'(pa);
    p.prev_magnitude = MAG_BITS'(pm);
    p.new_angle      = ANGLE_W'(na);
    p.new_magnitude  = MAG_BITS'(nm);
    send_pair(p);
  endtask

  // result side: runs of ready broken by stalls
  initial begin
    int g;
    forever begin
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      g = pick_gap();
      if (g > 0) begin
        res_ch.ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  // ------------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    blend_t exp_b;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_blends.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result beat angle %0d magnitude %0d zero_sum %0b",
                 $time, res_ch.blended_angle, res_ch.blended_magnitude, res_ch.zero_sum);
      end else begin
        exp_b = pending_blends.pop_front();
        if (res_ch.blended_angle !== exp_b.angle) begin
          mismatches++;
          $display("%0t blended_angle expected %0d actual %0d",
                   $time, exp_b.angle, res_ch.blended_angle);
        end
        if (res_ch.blended_magnitude !== exp_b.magnitude) begin
          mismatches++;
          $display("%0t blended_magnitude expected %0d actual %0d",
                   $time, exp_b.magnitude, res_ch.blended_magnitude);
        end
        if (res_ch.zero_sum !== exp_b.zero) begin
          mismatches++;
          $display("%0t zero_sum expected %0b actual %0b",
                   $time, exp_b.zero, res_ch.zero_sum);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("flow_angle_magnitude_blend_core verification failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  task automatic test_reset_weights();
    send_fields(0, 0, 0, 0);
    send_fields(359, 4095, 359, 4095);
    send_fields(0, 4095, 180, 0);
    send_fields(90, 0, 270, 4095);
    send_fields(360, 1234, 0, 2345);
    send_fields(511, 4095, 511, 0);
    send_fields(1, 2048, 359, 2047);
    send_fields(45, 100, 315, 3000);
  endtask

  // equal weights on opposite directions; most of these pairs cancel exactly
  task automatic test_cancelling_directions();
    write_reg(REG_ANGLE_WEIGHT, CFG_DATA_W'(128));
    send_fields(0, 10, 180, 20);
    send_fields(90, 4095, 270, 4095);
    send_fields(45, 7, 225, 9);
    send_fields(359, 0, 179, 1);
    send_fields(400, 50, 220, 60);
  endtask

  task automatic test_weight_extremes();
    write_reg(REG_ANGLE_WEIGHT, CFG_DATA_W'(0));
    write_reg(REG_MAGNITUDE_WEIGHT, CFG_DATA_W'(0));
    send_fields(123, 4095, 300, 0);
    send_fields(270, 0, 90, 4095);
    write_reg(REG_ANGLE_WEIGHT, CFG_DATA_W'(256));
    write_reg(REG_MAGNITUDE_WEIGHT, CFG_DATA_W'(256));
    send_fields(10, 4095, 200, 17);
    send_fields(180, 0, 359, 4095);
    // weights above one act as one
    write_reg(REG_ANGLE_WEIGHT, '1);
    write_reg(REG_MAGNITUDE_WEIGHT, CFG_DATA_W'(300));
    send_fields(33, 4000, 180, 5);
    send_fields(0, 1, 270, 4095);
  endtask

  task automatic test_unmapped_register();
    write_reg(REG_UNMAPPED, CFG_DATA_W'(3));
    send_fields(60, 999, 240, 1);
    send_fields(350, 4095, 10, 4094);
  endtask

  function automatic int rand_angle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 359);
    if (r < 90) return 45 * $urandom_range(0, 7);
    return $urandom_range(360, 511);
  endfunction

  function automatic int rand_magnitude();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 16) return 4095;
    return $urandom_range(0, 4095);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_weight();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return CFG_DATA_W'(0);
      1: return CFG_DATA_W'(256);
      2: return CFG_DATA_W'(128);
      3: return '1;
      4: return CFG_DATA_W'(255);
      default: return CFG_DATA_W'($urandom_range(0, 511));
    endcase
  endfunction

  task automatic test_random_blends();
    logic [CFG_DATA_W-1:0] aw_set [7];
    logic [CFG_DATA_W-1:0] mw_set [7];
    int pa, na;
    aw_set = '{CFG_DATA_W'(128), CFG_DATA_W'(0), CFG_DATA_W'(256), rand_weight(),
               '1, CFG_DATA_W'(1), rand_weight()};
    mw_set = '{rand_weight(), CFG_DATA_W'(256), CFG_DATA_W'(0), CFG_DATA_W'(300),
               CFG_DATA_W'(255), CFG_DATA_W'(1), rand_weight()};
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_ANGLE_WEIGHT, aw_set[ph]);
      write_reg(REG_MAGNITUDE_WEIGHT, mw_set[ph]);
      for (int n = 0; n < 120; n++) begin
        // back-to-back stretches in part of each phase
        calm = (n >= 40 && n < 70);
        pa = rand_angle();
        if ($urandom_range(0, 9) == 0) na = (pa % 360 + 180) % 360;
        else na = rand_angle();
        send_fields(pa, rand_magnitude(), na, rand_magnitude());
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    angle_wt = ANGLE_WEIGHT_RESET;
    magnitude_wt = MAGNITUDE_WEIGHT_RESET;
    item_ch.valid <= 1'b0;
    item_ch.prev_angle <= '0;
    item_ch.prev_magnitude <= '0;
    item_ch.new_angle <= '0;
    item_ch.new_magnitude <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_weights();
    test_cancelling_directions();
    test_weight_extremes();
    test_unmapped_register();
    test_random_blends();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("flow_angle_magnitude_blend_core verification clean");
    end else begin
      $display("flow_angle_magnitude_blend_core verification failed");
    end
    $finish;
  end

endmodule

### sim.f
src/famb_pkg.sv
src/famb_if.sv
src/flow_angle_magnitude_blend_core.sv
sim/tb_top.sv
